// File: rtl/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// Types and codes shared by the contiguous frame allocator modules.
// ----------------------------------------------------------------------------
package cfa_pkg;

    localparam int ADDR_W  = 29;
    localparam int COUNT_W = 8;
    localparam int FIU_W   = 9;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic CFG_BASE_ADDRESS  = 1'b0;
    localparam logic CFG_FRAMES_IN_USE = 1'b1;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_NOFIT = 2'd1;
    localparam status_t ST_BAD   = 2'd2;

    typedef struct packed {
        logic                 req_type;
        logic [COUNT_W-1:0]   page_count;
        logic [ADDR_W-1:0]    address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]    result_address;
        logic [COUNT_W-1:0]   frame_count;
        status_t              status;
    } resp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]    base_address;
        logic [FIU_W-1:0]     frames_in_use;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_A_CHK,
        ST_A_SCAN,
        ST_A_MARK,
        ST_F_CHK,
        ST_F_READ,
        ST_F_CLEAR,
        ST_RESP
    } state_t;

endpackage

// File: rtl/cfa_ram.sv
// ----------------------------------------------------------------------------
// cfa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cfa_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/cfa_ctrl.sv
// ----------------------------------------------------------------------------
// cfa_ctrl
// Sequencer: clearing pass, first-fit scan, run marking and run freeing.
// ----------------------------------------------------------------------------
module cfa_ctrl #(
    parameter int MAX_FRAMES = 256,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfa_pkg::cfg_t                 cfg,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  cfa_pkg::req_t                 req,
    output logic                          res_valid,
    input  logic                          res_ready,
    output cfa_pkg::resp_t                res,
    output logic                          used_we,
    output logic [$clog2(MAX_FRAMES)-1:0] used_waddr,
    output logic                          used_wdata,
    output logic [$clog2(MAX_FRAMES)-1:0] used_raddr,
    input  logic                          used_rdata,
    output logic                          len_we,
    output logic [$clog2(MAX_FRAMES)-1:0] len_waddr,
    output logic [cfa_pkg::COUNT_W-1:0]   len_wdata,
    output logic [$clog2(MAX_FRAMES)-1:0] len_raddr,
    input  logic [cfa_pkg::COUNT_W-1:0]   len_rdata
);

    localparam int IW       = $clog2(MAX_FRAMES);
    localparam int NW0      = $clog2(MAX_FRAMES + 1);
    localparam int NW       = (NW0 > cfa_pkg::FIU_W) ? NW0 : cfa_pkg::FIU_W;
    localparam int PB_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDXW     = cfa_pkg::ADDR_W - PB_SHIFT;
    localparam int CW       = (IDXW > NW) ? IDXW : NW;
    localparam int AW       = cfa_pkg::ADDR_W;
    localparam int KW       = cfa_pkg::COUNT_W;

    cfa_pkg::state_t     state_reg, state_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [KW-1:0]       cnt_reg, cnt_next;
    cfa_pkg::req_t       req_reg, req_next;
    cfa_pkg::resp_t      res_reg, res_next;

    logic [NW-1:0]       n_frames;
    logic [NW-1:0]       fiu_ext;
    logic [NW-1:0]       count_ext;
    logic [NW-1:0]       start_wide;
    logic [AW-1:0]       offset;
    logic [IDXW-1:0]     free_frame;
    logic                free_bad;
    logic [KW:0]         run_inc;

    // managed frame count: register value clamped to the built capacity
    assign fiu_ext  = NW'(cfg.frames_in_use);
    assign n_frames = (fiu_ext > NW'(MAX_FRAMES)) ? NW'(MAX_FRAMES) : fiu_ext;
    assign count_ext = NW'(req_reg.page_count);

    assign run_inc    = {1'b0, cnt_reg} + (KW+1)'(1);
    assign start_wide = NW'(idx_reg) + NW'(1) - count_ext;

    assign offset     = req_reg.address - cfg.base_address;
    assign free_frame = offset[AW-1:PB_SHIFT];
    assign free_bad   = (req_reg.address < cfg.base_address)
                     || (offset[PB_SHIFT-1:0] != '0)
                     || (free_frame == '0)
                     || (CW'(free_frame) >= CW'(n_frames));

    assign req_ready = (state_reg == cfa_pkg::ST_IDLE);
    assign res_valid = (state_reg == cfa_pkg::ST_RESP);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfa_pkg::ST_INIT;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        used_we    = 1'b0;
        used_waddr = idx_reg;
        used_wdata = 1'b0;
        used_raddr = idx_reg;
        len_we     = 1'b0;
        len_waddr  = idx_reg;
        len_wdata  = '0;
        len_raddr  = idx_reg;

        unique case (state_reg)
            cfa_pkg::ST_INIT:
            begin
                // frame zero stays reserved with a run of one
                used_we    = 1'b1;
                used_wdata = (idx_reg == '0);
                len_we     = 1'b1;
                len_wdata  = (idx_reg == '0) ? KW'(1) : '0;
                idx_next   = idx_reg + IW'(1);
                if (idx_reg == IW'(MAX_FRAMES - 1))
                begin
                    idx_next   = '0;
                    state_next = cfa_pkg::ST_IDLE;
                end
            end

            cfa_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = (req.req_type == cfa_pkg::REQ_ALLOC) ?
                                 cfa_pkg::ST_A_CHK : cfa_pkg::ST_F_CHK;
                end
            end

            cfa_pkg::ST_A_CHK:
            begin
                res_next.result_address = '0;
                res_next.frame_count    = '0;
                if ((req_reg.page_count == '0) || (count_ext > n_frames))
                begin
                    res_next.status = cfa_pkg::ST_BAD;
                    state_next      = cfa_pkg::ST_RESP;
                end
                else if (n_frames < NW'(2))
                begin
                    res_next.status = cfa_pkg::ST_NOFIT;
                    state_next      = cfa_pkg::ST_RESP;
                end
                else
                begin
                    used_raddr = IW'(1);
                    idx_next   = IW'(1);
                    cnt_next   = '0;
                    state_next = cfa_pkg::ST_A_SCAN;
                end
            end

            cfa_pkg::ST_A_SCAN:
            begin
                // read data belongs to idx_reg; fetch the next frame meanwhile
                used_raddr = idx_reg + IW'(1);
                idx_next   = idx_reg + IW'(1);
                if (!used_rdata)
                begin
                    cnt_next = run_inc[KW-1:0];
                end
                else
                begin
                    cnt_next = '0;
                end
                if (!used_rdata && (run_inc == {1'b0, req_reg.page_count}))
                begin
                    idx_next   = start_wide[IW-1:0];
                    cnt_next   = req_reg.page_count;
                    state_next = cfa_pkg::ST_A_MARK;
                    res_next.result_address = cfg.base_address
                                            + (AW'(start_wide[IW-1:0]) << PB_SHIFT);
                    res_next.frame_count    = req_reg.page_count;
                    res_next.status         = cfa_pkg::ST_OK;
                end
                else if (NW'(idx_reg) == n_frames - NW'(1))
                begin
                    res_next.status = cfa_pkg::ST_NOFIT;
                    state_next      = cfa_pkg::ST_RESP;
                end
            end

            cfa_pkg::ST_A_MARK:
            begin
                used_we    = 1'b1;
                used_wdata = 1'b1;
                if (cnt_reg == req_reg.page_count)
                begin
                    len_we    = 1'b1;
                    len_wdata = req_reg.page_count;
                end
                idx_next = idx_reg + IW'(1);
                cnt_next = cnt_reg - KW'(1);
                if (cnt_reg == KW'(1))
                begin
                    state_next = cfa_pkg::ST_RESP;
                end
            end

            cfa_pkg::ST_F_CHK:
            begin
                res_next.result_address = '0;
                res_next.frame_count    = '0;
                if (free_bad)
                begin
                    res_next.status = cfa_pkg::ST_BAD;
                    state_next      = cfa_pkg::ST_RESP;
                end
                else
                begin
                    len_raddr  = free_frame[IW-1:0];
                    idx_next   = free_frame[IW-1:0];
                    state_next = cfa_pkg::ST_F_READ;
                end
            end

            cfa_pkg::ST_F_READ:
            begin
                if (len_rdata == '0)
                begin
                    res_next.status = cfa_pkg::ST_BAD;
                    state_next      = cfa_pkg::ST_RESP;
                end
                else
                begin
                    len_we               = 1'b1;
                    len_wdata            = '0;
                    cnt_next             = len_rdata;
                    res_next.frame_count = len_rdata;
                    res_next.status      = cfa_pkg::ST_OK;
                    state_next           = cfa_pkg::ST_F_CLEAR;
                end
            end

            cfa_pkg::ST_F_CLEAR:
            begin
                // stop at the table end even if the run claims more
                used_we    = 1'b1;
                used_wdata = 1'b0;
                idx_next   = idx_reg + IW'(1);
                cnt_next   = cnt_reg - KW'(1);
                if ((cnt_reg == KW'(1)) || (idx_reg == IW'(MAX_FRAMES - 1)))
                begin
                    state_next = cfa_pkg::ST_RESP;
                end
            end

            cfa_pkg::ST_RESP:
            begin
                if (res_ready)
                begin
                    state_next = cfa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cfa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/contiguous_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// contiguous_frame_allocator_core
// First-fit contiguous page-frame allocator with used-bit and run-length RAMs.
// ----------------------------------------------------------------------------
// Allocate: after the request check the scan reads the used-bit RAM one frame per
//   cycle, first fit, and the run found is then marked used.
// Free: the run length is read and zeroed; one used bit is cleared per cycle.
// One request is in work at a time; the output register holds one result.
// After reset a clearing pass over all MAX_FRAMES entries initializes both RAMs
// before the first request is taken; config writes are taken throughout.
module contiguous_frame_allocator_core #(
    parameter int MAX_FRAMES = 256,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic                        cfg_index,
    input  logic [cfa_pkg::ADDR_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cfa_pkg::req_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cfa_pkg::resp_t              out_data
);

    localparam int IW = $clog2(MAX_FRAMES);

    cfa_pkg::cfg_t   cfg_reg;
    logic            out_valid_reg;
    cfa_pkg::resp_t  out_data_reg;

    logic            res_valid;
    logic            res_ready;
    cfa_pkg::resp_t  res;

    logic                         used_we;
    logic [IW-1:0]                used_waddr;
    logic                         used_wdata;
    logic [IW-1:0]                used_raddr;
    logic                         used_rdata;
    logic                         len_we;
    logic [IW-1:0]                len_waddr;
    logic [cfa_pkg::COUNT_W-1:0]  len_wdata;
    logic [IW-1:0]                len_raddr;
    logic [cfa_pkg::COUNT_W-1:0]  len_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_address  <= '0;
            cfg_reg.frames_in_use <= cfa_pkg::FIU_W'(256);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                cfa_pkg::CFG_BASE_ADDRESS:  cfg_reg.base_address  <= cfg_data;
                cfa_pkg::CFG_FRAMES_IN_USE:
                    cfg_reg.frames_in_use <= cfg_data[cfa_pkg::FIU_W-1:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    // output register frees up when empty or when its transfer completes
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    cfa_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .req_valid  (in_valid),
        .req_ready  (in_ready),
        .req        (in_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .used_we    (used_we),
        .used_waddr (used_waddr),
        .used_wdata (used_wdata),
        .used_raddr (used_raddr),
        .used_rdata (used_rdata),
        .len_we     (len_we),
        .len_waddr  (len_waddr),
        .len_wdata  (len_wdata),
        .len_raddr  (len_raddr),
        .len_rdata  (len_rdata)
    );

    cfa_ram #(
        .DEPTH (MAX_FRAMES),
        .WIDTH (1)
    ) u_used_ram (
        .clk   (clk),
        .we    (used_we),
        .waddr (used_waddr),
        .wdata (used_wdata),
        .raddr (used_raddr),
        .rdata (used_rdata)
    );

    cfa_ram #(
        .DEPTH (MAX_FRAMES),
        .WIDTH (cfa_pkg::COUNT_W)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

endmodule
